// ===== design/rpas_pkg.sv =====
// Shared types and constants of the round-robin / priority scheduler with aging.
// Holds the item and result word layouts, the sequencer states and the code names.
// No dependencies.
package rpas_pkg;

    localparam int DEF_MAX_SLOTS  = 64;
    localparam int DEF_BURST_BITS = 16;

    localparam int SLOT_FIELD_W  = 6;
    localparam int BURST_FIELD_W = 16;
    localparam int PRIO_W        = 8;
    localparam int PRIO_WORD_W   = PRIO_W + 1;
    localparam int QUANTA_W      = 8;
    localparam int TICK_W        = 9;
    localparam int CFG_IDX_W     = 1;

    localparam logic [QUANTA_W-1:0] RR_QUANTA_RST   = 8'd30;
    localparam logic [QUANTA_W-1:0] PRIO_QUANTA_RST = 8'd30;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 8'sh80;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_TICK  = 1'b1;
    localparam logic PHASE_RR   = 1'b0;
    localparam logic PHASE_PRIO = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RR_QUANTA   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_QUANTA = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [BURST_FIELD_W-1:0] burst;
        logic signed [PRIO_W-1:0] prio_in;
    } item_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0]  chosen_slot;
        logic                     phase;
        logic [BURST_FIELD_W-1:0] burst_left;
        logic                     finished;
        logic                     all_done;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic burst_we;
        logic prio_we;
    } mem_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_AGE
    } sched_state_t;

endpackage

// ===== design/rpas_store.sv =====
// Slot tables: burst memory and priority memory (valid bit plus signed priority).
// One write port each, one shared read address, registered read data.
// Depends on rpas_pkg.
module rpas_store
    import rpas_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int BURST_BITS = DEF_BURST_BITS,
    localparam int SLOT_W    = $clog2(MAX_SLOTS)
)
(
    input  logic                   clk,
    input  mem_ctl_t               mem_ctl,
    input  logic [SLOT_W-1:0]      rd_addr,
    input  logic [SLOT_W-1:0]      burst_waddr,
    input  logic [BURST_BITS-1:0]  burst_wdata,
    input  logic [SLOT_W-1:0]      prio_waddr,
    input  logic [PRIO_WORD_W-1:0] prio_wdata,
    output logic [BURST_BITS-1:0]  burst_rdata,
    output logic [PRIO_WORD_W-1:0] prio_rdata
);

    logic [BURST_BITS-1:0]  burst_mem [MAX_SLOTS];
    logic [PRIO_WORD_W-1:0] prio_mem  [MAX_SLOTS];

    always_ff @(posedge clk)
    begin
        if (mem_ctl.burst_we)
        begin
            burst_mem[burst_waddr] <= burst_wdata;
        end
        if (mem_ctl.rd_en)
        begin
            burst_rdata <= burst_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.prio_we)
        begin
            prio_mem[prio_waddr] <= prio_wdata;
        end
        if (mem_ctl.rd_en)
        begin
            prio_rdata <= prio_mem[rd_addr];
        end
    end

endmodule

// ===== design/rpas_ctrl.sv =====
// Scheduler sequencer: clear pass, table scan, pick resolve, aging sweep.
// Drives the slot memories in rpas_store and builds the result word.
// Depends on rpas_pkg.
module rpas_ctrl
    import rpas_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int BURST_BITS = DEF_BURST_BITS,
    localparam int SLOT_W    = $clog2(MAX_SLOTS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  item_t                  item,
    input  logic [QUANTA_W-1:0]    rr_quanta,
    input  logic [QUANTA_W-1:0]    prio_quanta,
    output logic                   busy,
    output logic                   res_valid,
    output result_t                res,
    output mem_ctl_t               mem_ctl,
    output logic [SLOT_W-1:0]      rd_addr,
    output logic [SLOT_W-1:0]      burst_waddr,
    output logic [BURST_BITS-1:0]  burst_wdata,
    output logic [SLOT_W-1:0]      prio_waddr,
    output logic [PRIO_WORD_W-1:0] prio_wdata,
    input  logic [BURST_BITS-1:0]  burst_rdata,
    input  logic [PRIO_WORD_W-1:0] prio_rdata
);

    localparam int CNT_W = SLOT_W + 1;

    sched_state_t             state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     pend_reg, pend_next;
    logic [SLOT_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                     found_reg, found_next;
    logic [SLOT_W-1:0]        best_idx_reg, best_idx_next;
    logic [BURST_BITS-1:0]    best_burst_reg, best_burst_next;
    logic signed [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [TICK_W-1:0]        tick_reg, tick_next;
    logic                     phase_reg, phase_next;
    logic [SLOT_W-1:0]        scan_ptr_reg, scan_ptr_next;
    logic                     parity_reg, parity_next;
    logic [SLOT_W-1:0]        prev_pick_reg, prev_pick_next;

    logic                     cnt_done;
    logic                     issue;
    logic [SLOT_W-1:0]        cnt_idx;
    logic [SLOT_W-1:0]        base_idx;
    logic [CNT_W-1:0]         scan_sum;
    logic [CNT_W-1:0]         scan_wrap;
    logic [SLOT_W-1:0]        scan_addr;
    logic                     rd_live;
    logic signed [PRIO_W-1:0] rd_prio;
    logic                     take;
    logic                     age_hit;
    logic                     load_ok;
    logic [BURST_BITS-1:0]    left;
    logic [QUANTA_W-1:0]      limit;
    logic [TICK_W-1:0]        tick_inc;

    assign busy     = (state_reg != ST_IDLE);
    assign cnt_done = (cnt_reg == CNT_W'(MAX_SLOTS));
    assign cnt_idx  = cnt_reg[SLOT_W-1:0];
    assign issue    = ((state_reg == ST_SCAN) || (state_reg == ST_AGE)) && !cnt_done;

    assign base_idx  = (phase_reg == PHASE_RR) ? scan_ptr_reg : '0;
    assign scan_sum  = {1'b0, base_idx} + cnt_reg;
    assign scan_wrap = (scan_sum >= CNT_W'(MAX_SLOTS)) ? scan_sum - CNT_W'(MAX_SLOTS)
                                                       : scan_sum;
    assign scan_addr = scan_wrap[SLOT_W-1:0];

    assign rd_prio = signed'(prio_rdata[PRIO_W-1:0]);
    assign rd_live = prio_rdata[PRIO_W] && (burst_rdata != '0);
    assign take    = rd_live && (!found_reg ||
                                 ((phase_reg == PHASE_PRIO) && (rd_prio < best_prio_reg)));
    assign age_hit = prio_rdata[PRIO_W] && (pend_idx_reg != prev_pick_reg) &&
                     (pend_idx_reg != best_idx_reg) && (rd_prio != PRIO_MIN);

    assign load_ok = (32'(item.slot) < 32'(MAX_SLOTS));
    assign left    = best_burst_reg - BURST_BITS'(1);
    assign tick_inc = tick_reg + TICK_W'(1);

    always_comb
    begin
        if (phase_reg == PHASE_RR)
        begin
            limit = (rr_quanta == '0) ? QUANTA_W'(1) : rr_quanta;
        end
        else
        begin
            limit = (prio_quanta == '0) ? QUANTA_W'(1) : prio_quanta;
        end
    end

    // next state
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = issue;
        pend_idx_next   = (state_reg == ST_SCAN) ? scan_addr : cnt_idx;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_burst_next = best_burst_reg;
        best_prio_next  = best_prio_reg;
        tick_next       = tick_reg;
        phase_next      = phase_reg;
        scan_ptr_next   = scan_ptr_reg;
        parity_next     = parity_reg;
        prev_pick_next  = prev_pick_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && (item.mode == MODE_TICK))
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && take)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = pend_idx_reg;
                    best_burst_next = burst_rdata;
                    best_prio_next  = rd_prio;
                end
                if (cnt_done)
                begin
                    state_next = ST_RESOLVE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_RESOLVE:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
                if (found_reg)
                begin
                    if (phase_reg == PHASE_RR)
                    begin
                        scan_ptr_next = (best_idx_reg == SLOT_W'(MAX_SLOTS - 1))
                                        ? '0 : best_idx_reg + SLOT_W'(1);
                    end
                    else if (!parity_reg)
                    begin
                        prev_pick_next = best_idx_reg;
                        parity_next    = 1'b1;
                    end
                    else
                    begin
                        parity_next = 1'b0;
                        state_next  = ST_AGE;
                    end
                    if (tick_inc >= {1'b0, limit})
                    begin
                        tick_next = '0;
                        if (phase_reg == PHASE_RR)
                        begin
                            phase_next  = PHASE_PRIO;
                            parity_next = 1'b0;
                        end
                        else
                        begin
                            phase_next    = PHASE_RR;
                            scan_ptr_next = '0;
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
            end
            ST_AGE:
            begin
                if (cnt_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        mem_ctl     = '0;
        rd_addr     = '0;
        burst_waddr = '0;
        burst_wdata = '0;
        prio_waddr  = '0;
        prio_wdata  = '0;
        res_valid   = 1'b0;
        res         = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.prio_we = 1'b1;
                prio_waddr      = cnt_idx;
            end
            ST_IDLE:
            begin
                if (start && (item.mode == MODE_LOAD) && load_ok)
                begin
                    mem_ctl.burst_we = 1'b1;
                    mem_ctl.prio_we  = 1'b1;
                    burst_waddr      = SLOT_W'(item.slot);
                    prio_waddr       = SLOT_W'(item.slot);
                    burst_wdata      = BURST_BITS'(item.burst);
                    prio_wdata       = {1'b1, item.prio_in};
                end
            end
            ST_SCAN:
            begin
                mem_ctl.rd_en = issue;
                rd_addr       = scan_addr;
            end
            ST_RESOLVE:
            begin
                res_valid = 1'b1;
                res.phase = phase_reg;
                if (found_reg)
                begin
                    mem_ctl.burst_we = 1'b1;
                    burst_waddr      = best_idx_reg;
                    burst_wdata      = left;
                    res.chosen_slot  = SLOT_FIELD_W'(best_idx_reg);
                    res.burst_left   = BURST_FIELD_W'(left);
                    res.finished     = (left == '0);
                end
                else
                begin
                    res.all_done = 1'b1;
                end
            end
            ST_AGE:
            begin
                mem_ctl.rd_en = issue;
                rd_addr       = cnt_idx;
                if (pend_reg && age_hit)
                begin
                    mem_ctl.prio_we = 1'b1;
                    prio_waddr      = pend_idx_reg;
                    prio_wdata      = {1'b1, rd_prio - PRIO_W'(1)};
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            tick_reg      <= '0;
            phase_reg     <= PHASE_RR;
            scan_ptr_reg  <= '0;
            parity_reg    <= 1'b0;
            prev_pick_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            tick_reg      <= tick_next;
            phase_reg     <= phase_next;
            scan_ptr_reg  <= scan_ptr_next;
            parity_reg    <= parity_next;
            prev_pick_reg <= prev_pick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_burst_reg <= best_burst_next;
        best_prio_reg  <= best_prio_next;
    end

    a_res_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(state_reg == ST_SCAN))
        else $error("result word without a completed scan");

    a_no_rd_on_burst_wr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.burst_we |-> !mem_ctl.rd_en)
        else $error("burst write overlaps a table read");

    a_age_skips_picks: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.prio_we && (state_reg == ST_AGE)) |->
        ((prio_waddr != prev_pick_reg) && (prio_waddr != best_idx_reg)))
        else $error("aging touched a just-picked slot");

    a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.mode == MODE_TICK)) |=> (state_reg == ST_SCAN))
        else $error("accepted tick did not start a scan");

endmodule

// ===== design/rr_priority_aging_scheduler.sv =====
// Top level of the round-robin / priority scheduler with aging.
// Holds the quanta registers and the result register; uses rpas_ctrl and rpas_store.
// Depends on rpas_pkg.
//
// Usage:
//   Input words enter on item and are taken at a clock edge with start high and
//   busy low. A load word (mode 0) writes one slot in that cycle; busy stays low.
//   A tick word (mode 1) scans the whole slot table through the memory read port,
//   one slot a cycle, with busy high throughout, and the result word appears on
//   result with done high for exactly one cycle, registered after the resolve step.
//   On every second pick of the priority phase an aging sweep of the priority
//   memory follows, and busy stays high through it. A tick therefore keeps busy
//   high through the scan, the resolve step and any aging sweep, and the next word
//   is taken only once busy is low again; the scan runs through the single shared
//   read port of the slot memories.
//   Loads produce no result. The receiver cannot stall: done is a strobe.
//   cfg_we writes rr_quanta (index 0) or prio_quanta (index 1) from cfg_data;
//   write only while the block is idle.
//   After reset a clearing pass marks every slot empty; busy is high during it.
//   Both quanta registers reset to 30.
module rr_priority_aging_scheduler
    import rpas_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int BURST_BITS = DEF_BURST_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  item_t                item,
    output logic                 busy,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [QUANTA_W-1:0]  cfg_data
);

    localparam int SLOT_W = $clog2(MAX_SLOTS);

    logic [QUANTA_W-1:0]    rr_quanta_reg, rr_quanta_next;
    logic [QUANTA_W-1:0]    prio_quanta_reg, prio_quanta_next;
    logic                   done_reg;
    result_t                result_reg;

    logic                   res_valid;
    result_t                res;
    mem_ctl_t               mem_ctl;
    logic [SLOT_W-1:0]      rd_addr;
    logic [SLOT_W-1:0]      burst_waddr;
    logic [BURST_BITS-1:0]  burst_wdata;
    logic [SLOT_W-1:0]      prio_waddr;
    logic [PRIO_WORD_W-1:0] prio_wdata;
    logic [BURST_BITS-1:0]  burst_rdata;
    logic [PRIO_WORD_W-1:0] prio_rdata;

    always_comb
    begin
        rr_quanta_next   = rr_quanta_reg;
        prio_quanta_next = prio_quanta_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RR_QUANTA:   rr_quanta_next   = cfg_data;
                CFG_PRIO_QUANTA: prio_quanta_next = cfg_data;
                default:         rr_quanta_next   = rr_quanta_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_quanta_reg   <= RR_QUANTA_RST;
            prio_quanta_reg <= PRIO_QUANTA_RST;
            done_reg        <= 1'b0;
        end
        else
        begin
            rr_quanta_reg   <= rr_quanta_next;
            prio_quanta_reg <= prio_quanta_next;
            done_reg        <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= res;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    rpas_ctrl #(
        .MAX_SLOTS  (MAX_SLOTS),
        .BURST_BITS (BURST_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .rr_quanta   (rr_quanta_reg),
        .prio_quanta (prio_quanta_reg),
        .busy        (busy),
        .res_valid   (res_valid),
        .res         (res),
        .mem_ctl     (mem_ctl),
        .rd_addr     (rd_addr),
        .burst_waddr (burst_waddr),
        .burst_wdata (burst_wdata),
        .prio_waddr  (prio_waddr),
        .prio_wdata  (prio_wdata),
        .burst_rdata (burst_rdata),
        .prio_rdata  (prio_rdata)
    );

    rpas_store #(
        .MAX_SLOTS  (MAX_SLOTS),
        .BURST_BITS (BURST_BITS)
    ) u_store (
        .clk         (clk),
        .mem_ctl     (mem_ctl),
        .rd_addr     (rd_addr),
        .burst_waddr (burst_waddr),
        .burst_wdata (burst_wdata),
        .prio_waddr  (prio_waddr),
        .prio_wdata  (prio_wdata),
        .burst_rdata (burst_rdata),
        .prio_rdata  (prio_rdata)
    );

endmodule
